// ===== src/sme_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types and codes for the stack-machine execute block.
// ----------------------------------------------------------------------------
package sme_pkg;

    // instruction codes
    localparam logic [4:0] CMD_PUSH_IMM  = 5'd0;
    localparam logic [4:0] CMD_PUSH_REG  = 5'd1;
    localparam logic [4:0] CMD_PUSH_MI   = 5'd2;
    localparam logic [4:0] CMD_PUSH_MR   = 5'd3;
    localparam logic [4:0] CMD_PUSH_MRI  = 5'd4;
    localparam logic [4:0] CMD_POP       = 5'd5;
    localparam logic [4:0] CMD_POP_REG   = 5'd6;
    localparam logic [4:0] CMD_POP_MI    = 5'd7;
    localparam logic [4:0] CMD_POP_MR    = 5'd8;
    localparam logic [4:0] CMD_POP_MRI   = 5'd9;
    localparam logic [4:0] CMD_ADD       = 5'd10;
    localparam logic [4:0] CMD_SUB       = 5'd11;
    localparam logic [4:0] CMD_MUL       = 5'd12;
    localparam logic [4:0] CMD_DIV       = 5'd13;
    localparam logic [4:0] CMD_DUP       = 5'd14;
    localparam logic [4:0] CMD_OUT       = 5'd15;
    localparam logic [4:0] CMD_JMP       = 5'd16;
    localparam logic [4:0] CMD_JB        = 5'd17;
    localparam logic [4:0] CMD_JBE       = 5'd18;
    localparam logic [4:0] CMD_JA        = 5'd19;
    localparam logic [4:0] CMD_JAE       = 5'd20;
    localparam logic [4:0] CMD_JE        = 5'd21;
    localparam logic [4:0] CMD_JNE       = 5'd22;
    localparam logic [4:0] CMD_HALT      = 5'd23;

    // status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_HALT   = 3'd1;
    localparam logic [2:0] ST_RANGE  = 3'd2;
    localparam logic [2:0] ST_FRAC   = 3'd3;
    localparam logic [2:0] ST_DIVZ   = 3'd4;
    localparam logic [2:0] ST_UNDER  = 3'd5;
    localparam logic [2:0] ST_OVER   = 3'd6;
    localparam logic [2:0] ST_BADCMD = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_WRITE,
        S_RESULT,
        S_CLEAR
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input beat
        logic decode;    // compute addresses and checks
        logic read;      // issue stack/ram reads
        logic exec;      // evaluate operation
        logic mul_step;  // one product stage
        logic div_start; // launch divider
        logic commit;    // write state and form result
        logic clear;     // clearing pass step
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic div_done;
        logic err;       // instruction failed or sticky error
        logic clear_done;
    } t_sts;

endpackage : sme_pkg
`default_nettype wire

// ===== src/sme_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sme_ctrl
// Sequencer: steps each instruction through decode, read, execute and commit.
// ----------------------------------------------------------------------------
module sme_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic          i_res_free,
    input  wire sme_pkg::t_sts i_sts,
    output sme_pkg::t_ctl      o_ctl
);
    import sme_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (i_sts.clear_done) n_state = S_IDLE;
            S_IDLE:   if (i_in_valid) n_state = S_DECODE;
            S_DECODE: n_state = S_READ;
            S_READ:   n_state = S_EXEC;
            S_EXEC: begin
                if (i_sts.err)         n_state = S_WRITE;
                else if (i_sts.is_mul) n_state = S_MUL;
                else if (i_sts.is_div) n_state = S_DIV;
                else                   n_state = S_WRITE;
            end
            S_MUL:    n_state = S_WRITE;
            S_DIV:    if (i_sts.div_done) n_state = S_WRITE;
            S_WRITE:  if (i_res_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_ctl      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR:  o_ctl.clear = 1'b1;
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.load = i_in_valid;
            end
            S_DECODE: o_ctl.decode = 1'b1;
            S_READ:   o_ctl.read = 1'b1;
            S_EXEC: begin
                o_ctl.exec      = 1'b1;
                o_ctl.div_start = i_sts.is_div && !i_sts.err;
            end
            S_MUL:    o_ctl.mul_step = 1'b1;
            // hold the commit while the output register is still occupied
            S_WRITE:  o_ctl.commit = i_res_free;
            default:  o_ctl = '0;
        endcase
    end

    // a beat is taken only from idle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |-> r_state == S_IDLE)
        else $error("load outside idle");
    a_commit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.commit |=> r_state == S_IDLE)
        else $error("commit not followed by idle");
    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("ready while busy");

endmodule : sme_ctrl
`default_nettype wire

// ===== src/sme_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sme_div
// Restoring divider, one quotient bit a cycle, signed with saturation.
// ----------------------------------------------------------------------------
module sme_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_num,
    input  wire logic signed [31:0] i_den,
    output logic                    o_done,
    output logic signed [31:0]      o_quot
);
    import sme_pkg::*;

    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_q;
    logic [32:0]   r_rem;
    logic [31:0]   r_den;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [32:0]   w_abs;
    logic [NW-1:0] w_mag;
    logic [33:0]   w_trial;
    logic [33:0]   w_shift;
    logic [NW:0]   w_sq;

    // absolute dividend shifted by the fraction width
    always_comb begin
        w_abs   = i_num[31] ? -33'(i_num) : 33'(i_num);
        w_mag   = NW'(w_abs) << FRAC_BITS;
        w_shift = {r_rem, r_q[NW-1]};
        w_trial = w_shift - {2'b00, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // quotient bit per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= w_mag;
            r_rem <= '0;
            r_den <= i_den[31] ? 32'(-i_den) : i_den;
            r_neg <= i_num[31] ^ i_den[31];
            r_cnt <= CW'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (!w_trial[33]) begin
                r_rem <= w_trial[32:0];
                r_q   <= {r_q[NW-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[32:0];
                r_q   <= {r_q[NW-2:0], 1'b0};
            end
        end
    end

    // sign and saturate
    always_comb begin
        w_sq = r_neg ? -{1'b0, r_q} : {1'b0, r_q};
        if (!r_neg && r_q > NW'(32'h7FFF_FFFF))
            o_quot = 32'sh7FFF_FFFF;
        else if (r_neg && r_q > NW'(33'h8000_0000))
            o_quot = 32'sh8000_0000;
        else
            o_quot = w_sq[31:0];
    end
    assign o_done = r_done;

endmodule : sme_div
`default_nettype wire

// ===== src/sme_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sme_dpath
// Operand stack, registers, data ram, checks and arithmetic units.
// ----------------------------------------------------------------------------
module sme_dpath #(
    parameter int STACK_DEPTH = 16,
    parameter int REG_COUNT   = 4,
    parameter int RAM_WORDS   = 256,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sme_pkg::t_ctl      i_ctl,
    output sme_pkg::t_sts           o_sts,
    input  wire logic [4:0]         i_command,
    input  wire logic [1:0]         i_reg_index,
    input  wire logic signed [31:0] i_immediate,
    input  wire logic signed [31:0] i_push_value,
    input  wire logic               i_res_ready,
    output logic                    o_res_valid,
    output logic [2:0]              o_status,
    output logic                    o_out_valid,
    output logic signed [31:0]      o_out_value,
    output logic                    o_jump_taken,
    output logic signed [31:0]      o_jump_target
);
    import sme_pkg::*;

    localparam int SW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int AW = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;

    // storage
    logic signed [31:0] r_stack [STACK_DEPTH];
    logic signed [31:0] r_ram   [RAM_WORDS];
    logic signed [31:0] r_regs  [REG_COUNT];
    logic [CW-1:0]      r_cnt;
    logic [2:0]         r_err;
    logic [AW:0]        r_clr;

    // captured instruction
    logic [4:0]         r_cmd;
    logic [RW-1:0]      r_ri;
    logic signed [31:0] r_imm, r_pv;

    // decode results
    logic [2:0]         r_chk;
    logic [AW-1:0]      r_addr;
    logic signed [31:0] r_a, r_b, r_m, r_res;
    logic signed [63:0] r_prod;
    logic               r_take;

    logic [2:0]         n_chk;
    logic [AW-1:0]      n_addr;
    logic signed [32:0] w_ipart;
    logic signed [33:0] w_rsum;
    logic [2:0]         w_rchk;
    logic               w_imm_ok;
    logic [RW-1:0]      w_ri;
    logic signed [31:0] w_reg;
    logic               w_push, w_pop, w_bin, w_cj;
    logic signed [32:0] w_sum;
    logic signed [63:0] w_shr;
    logic               w_div_done;
    logic signed [31:0] w_quot;
    logic [2:0]         w_xerr;

    // register index wraps by the register count; the index is below 4
    assign w_ri  = (REG_COUNT == 1) ? '0 :
                   (int'(i_reg_index) >= REG_COUNT) ? RW'(int'(i_reg_index) - REG_COUNT) :
                   RW'(i_reg_index);
    assign w_reg = r_regs[r_ri];

    // register-derived address: integer part plus offset, then range, then fraction
    always_comb begin
        w_ipart = (FRAC_BITS == 0) ? 33'(w_reg) : 33'(w_reg >>> FRAC_BITS);
        if (FRAC_BITS != 0 && w_reg[31] && (w_reg & ((32'sd1 <<< FRAC_BITS) - 1)) != 0)
            w_ipart = w_ipart + 33'sd1;
        w_rsum = 34'(w_ipart) + ((r_cmd == CMD_PUSH_MRI || r_cmd == CMD_POP_MRI) ?
                 34'(r_imm) : 34'sd0);
        if (w_rsum < 0 || w_rsum >= 34'(RAM_WORDS))
            w_rchk = ST_RANGE;
        else if (FRAC_BITS != 0 && (w_reg & ((32'sd1 <<< FRAC_BITS) - 1)) != 0)
            w_rchk = ST_FRAC;
        else
            w_rchk = ST_OK;
        w_imm_ok = (r_imm >= 0) && (33'(r_imm) < 33'(RAM_WORDS));
    end

    // check sequence per command
    always_comb begin
        n_chk  = ST_OK;
        n_addr = AW'(r_imm);
        w_push = 1'b0; w_pop = 1'b0; w_bin = 1'b0; w_cj = 1'b0;
        case (r_cmd)
            CMD_PUSH_IMM, CMD_PUSH_REG, CMD_PUSH_MI, CMD_PUSH_MR, CMD_PUSH_MRI: begin
                w_push = 1'b1;
                if (r_cmd == CMD_PUSH_MI) n_chk = w_imm_ok ? ST_OK : ST_RANGE;
                if (r_cmd == CMD_PUSH_MR || r_cmd == CMD_PUSH_MRI) begin
                    n_chk  = w_rchk;
                    n_addr = AW'(w_rsum);
                end
                if (n_chk == ST_OK && r_cnt >= CW'(STACK_DEPTH)) n_chk = ST_OVER;
            end
            CMD_POP, CMD_POP_REG, CMD_POP_MI, CMD_POP_MR, CMD_POP_MRI: begin
                w_pop = 1'b1;
                if (r_cmd == CMD_POP_MRI) begin
                    n_chk  = w_rchk;
                    n_addr = AW'(w_rsum);
                end
                if (n_chk == ST_OK && r_cnt == '0) n_chk = ST_UNDER;
                if (n_chk == ST_OK && r_cmd == CMD_POP_MI && !w_imm_ok) n_chk = ST_RANGE;
                if (n_chk == ST_OK && r_cmd == CMD_POP_MR) begin
                    n_chk  = w_rchk;
                    n_addr = AW'(w_rsum);
                end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                w_bin = 1'b1;
                if (r_cnt < CW'(2)) n_chk = ST_UNDER;
            end
            CMD_DUP: begin
                if (r_cnt == '0) n_chk = ST_UNDER;
                else if (r_cnt >= CW'(STACK_DEPTH)) n_chk = ST_OVER;
            end
            CMD_OUT: if (r_cnt == '0) n_chk = ST_UNDER;
            CMD_JMP: n_chk = ST_OK;
            CMD_JB, CMD_JBE, CMD_JA, CMD_JAE, CMD_JE, CMD_JNE: begin
                w_cj = 1'b1;
                if (r_cnt < CW'(2)) n_chk = ST_UNDER;
            end
            CMD_HALT: n_chk = ST_HALT;
            default:  n_chk = ST_BADCMD;
        endcase
        if (r_err != ST_OK) n_chk = r_err;
    end

    // late error: divide by zero
    assign w_xerr = (r_chk == ST_OK && r_cmd == CMD_DIV && r_b == 0) ? ST_DIVZ : r_chk;

    assign o_sts.is_mul     = (r_cmd == CMD_MUL);
    assign o_sts.is_div     = (r_cmd == CMD_DIV);
    assign o_sts.div_done   = w_div_done;
    assign o_sts.err        = (w_xerr != ST_OK);
    assign o_sts.clear_done = (r_clr == (AW + 1)'(RAM_WORDS - 1));

    // capture and decode
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_command;
            r_ri  <= w_ri;
            r_imm <= i_immediate;
            r_pv  <= i_push_value;
        end
        if (i_ctl.decode) begin
            r_chk  <= n_chk;
            r_addr <= n_addr;
        end
        if (i_ctl.exec) r_chk <= w_xerr;
    end

    // stack and ram reads, registered
    always_ff @(posedge i_clk) begin
        if (i_ctl.read) begin
            r_a <= r_stack[SW'(r_cnt - CW'(1))];
            r_b <= r_stack[SW'(r_cnt - CW'(2))];
            r_m <= r_ram[r_addr];
        end
    end

    // arithmetic
    assign w_sum = (r_cmd == CMD_SUB) ? 33'(r_a) - 33'(r_b) : 33'(r_a) + 33'(r_b);
    assign w_shr = r_prod >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_prod <= 64'(r_a) * 64'(r_b);
            if (w_sum > 33'sh0_7FFF_FFFF)       r_res <= 32'sh7FFF_FFFF;
            else if (w_sum < -33'sh0_8000_0000) r_res <= 32'sh8000_0000;
            else                                r_res <= w_sum[31:0];
            case (r_cmd)
                CMD_JB:  r_take <= r_a < r_b;
                CMD_JBE: r_take <= r_a <= r_b;
                CMD_JA:  r_take <= r_a > r_b;
                CMD_JAE: r_take <= r_a >= r_b;
                CMD_JE:  r_take <= r_a == r_b;
                CMD_JNE: r_take <= r_a != r_b;
                CMD_JMP: r_take <= 1'b1;
                default: r_take <= 1'b0;
            endcase
        end
        if (i_ctl.mul_step) begin
            if (w_shr > 64'sh7FFF_FFFF)       r_res <= 32'sh7FFF_FFFF;
            else if (w_shr < -64'sh8000_0000) r_res <= 32'sh8000_0000;
            else                              r_res <= w_shr[31:0];
        end
        if (w_div_done) r_res <= w_quot;
    end

    sme_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.div_start),
        .i_num   (r_a),
        .i_den   (r_b),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // stack writes
    always_ff @(posedge i_clk) begin
        if (i_ctl.commit && r_chk == ST_OK) begin
            if (w_push || r_cmd == CMD_DUP) begin
                case (r_cmd)
                    CMD_PUSH_IMM: r_stack[SW'(r_cnt)] <= r_pv;
                    CMD_PUSH_REG: r_stack[SW'(r_cnt)] <= w_reg;
                    CMD_DUP:      r_stack[SW'(r_cnt)] <= r_a;
                    default:      r_stack[SW'(r_cnt)] <= r_m;
                endcase
            end else if (w_bin) begin
                r_stack[SW'(r_cnt - CW'(2))] <= r_res;
            end
        end
    end

    // ram: clearing pass after reset, then pop stores
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_ram[AW'(r_clr)] <= '0;
        end else if (i_ctl.commit && r_chk == ST_OK &&
                     (r_cmd == CMD_POP_MI || r_cmd == CMD_POP_MR || r_cmd == CMD_POP_MRI)) begin
            r_ram[r_addr] <= r_a;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_err       <= ST_OK;
            r_clr       <= '0;
            o_res_valid <= 1'b0;
            for (int k = 0; k < REG_COUNT; k++) r_regs[k] <= '0;
        end else begin
            if (i_ctl.clear) r_clr <= r_clr + (AW + 1)'(1);
            if (i_ctl.commit) begin
                o_res_valid <= 1'b1;
                if (r_chk != ST_OK) begin
                    r_err <= r_chk;
                end else begin
                    if (w_push || r_cmd == CMD_DUP) r_cnt <= r_cnt + CW'(1);
                    if (w_pop || w_bin || r_cmd == CMD_OUT) r_cnt <= r_cnt - CW'(1);
                    if (w_cj) r_cnt <= r_cnt - CW'(2);
                    if (r_cmd == CMD_POP_REG) r_regs[r_ri] <= r_a;
                end
            end else if (o_res_valid && i_res_ready) begin
                o_res_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            o_status      <= r_chk;
            o_out_valid   <= r_chk == ST_OK && r_cmd == CMD_OUT;
            o_out_value   <= (r_chk == ST_OK && r_cmd == CMD_OUT) ? r_a : 32'sd0;
            o_jump_taken  <= r_chk == ST_OK && r_take;
            o_jump_target <= (r_chk == ST_OK && r_take) ? r_imm : 32'sd0;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ST_OK) |=> (r_err == $past(r_err)))
        else $error("sticky error changed");
    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.commit && r_err != ST_OK) |=> (r_cnt == $past(r_cnt)))
        else $error("state moved under sticky error");

endmodule : sme_dpath
`default_nettype wire

// ===== src/stack_machine_execute_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stack_machine_execute_top
// Executes one decoded stack-machine instruction per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries command, register index, immediate
//   and push value. Output channel o_valid/i_ready carries one result beat per
//   instruction: status, out value and jump decision.
//   The result passes the decode, read, execute and write steps after the input
//   beat is accepted, and the next beat is taken only back in idle. mul adds
//   one product stage, div adds the steps of the bit-serial divider. One
//   instruction is in flight at once. After reset the data ram is cleared, one
//   word a cycle, during which o_ready stays low.
//   The result sits in an output register; the next beat is accepted while
//   it waits, but a second result holds in the write step, with o_ready low,
//   until the first has been taken.
//   Errors and halt are sticky until reset.
// ----------------------------------------------------------------------------
module stack_machine_execute_top #(
    parameter int STACK_DEPTH = 16,
    parameter int REG_COUNT   = 4,
    parameter int RAM_WORDS   = 256,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [4:0]         i_command,
    input  wire logic [1:0]         i_reg_index,
    input  wire logic signed [31:0] i_immediate,
    input  wire logic signed [31:0] i_push_value,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [2:0]              o_status,
    output logic                    o_out_valid,
    output logic signed [31:0]      o_out_value,
    output logic                    o_jump_taken,
    output logic signed [31:0]      o_jump_target
);
    import sme_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;
    logic w_free;

    // commit lands only once the output register is empty or draining
    assign w_free = !o_valid || i_ready;

    sme_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_res_free (w_free),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    sme_dpath #(
        .STACK_DEPTH (STACK_DEPTH),
        .REG_COUNT   (REG_COUNT),
        .RAM_WORDS   (RAM_WORDS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .o_sts         (w_sts),
        .i_command     (i_command),
        .i_reg_index   (i_reg_index),
        .i_immediate   (i_immediate),
        .i_push_value  (i_push_value),
        .i_res_ready   (i_ready),
        .o_res_valid   (o_valid),
        .o_status      (o_status),
        .o_out_valid   (o_out_valid),
        .o_out_value   (o_out_value),
        .o_jump_taken  (o_jump_taken),
        .o_jump_target (o_jump_target)
    );

endmodule : stack_machine_execute_top
`default_nettype wire
